/* rtl/core/vertex_pack_dedup_indexer_unit_assert.svh */
// Assertion macros for the vertex dedup indexer.
`ifndef VERTEX_PACK_DEDUP_INDEXER_UNIT_ASSERT_SVH
`define VERTEX_PACK_DEDUP_INDEXER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define VPDI_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("vpdi assertion failed");
`define VPDI_ASSERT_NEXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |=> (b)) else $error("vpdi assertion failed");
`else
`define VPDI_ASSERT(lbl, prop)
`define VPDI_ASSERT_NEXT(lbl, a, b)
`endif
`endif

/* rtl/core/vpdi_pkg.sv */
// Shared types, constants and helpers for the vertex dedup indexer.
`default_nettype none
package vpdi_pkg;
	localparam int TABLE_SLOTS  = 8192;
	localparam int SLOT_W       = $clog2(TABLE_SLOTS);
	localparam int MAX_VERTICES = 4096;
	localparam int INDEX_LIMIT  = 4096;
	localparam int VLIMIT       = (MAX_VERTICES > INDEX_LIMIT) ? INDEX_LIMIT : MAX_VERTICES;
	localparam int VCNT_W       = 13;
	localparam int IDX_W        = 12;
	localparam int EPOCH_W      = 4;
	localparam int KEY_W        = 32;
	localparam int ENTRY_W      = EPOCH_W + KEY_W + IDX_W;
	localparam int OPND_W       = 17;
	localparam int RES_W        = 11;
	localparam logic [7:0] POS_SCALE = 8'd10;
	localparam logic [7:0] TEX_SCALE = 8'd255;
	localparam logic [2:0] NORMAL_NONE = 3'd6;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_OVER   = 2'd1;
	localparam logic [1:0] ST_NONORM = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [OPND_W-1:0] operand;
		logic              is_tex;
	} scale_req_t;

	function automatic logic [SLOT_W-1:0] slot_hash(input logic [KEY_W-1:0] word);
		slot_hash = word[SLOT_W-1:0] ^ word[KEY_W-1 -: SLOT_W];
	endfunction
endpackage
`default_nettype wire

/* rtl/core/vpdi_ram.sv */
// Generic single write, single registered read RAM.
`default_nettype none
module vpdi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/core/vpdi_scale.sv */
// Shared constant-scale unit: axis x10 >> 8, or texture x255 >> 16.
`default_nettype none
module vpdi_scale (
	input  wire vpdi_pkg::scale_req_t           req,
	output logic [vpdi_pkg::RES_W-1:0]          result
);
	import vpdi_pkg::*;

	logic [7:0]          factor;
	logic [OPND_W+7:0]   prod;

	always_comb begin
		factor = req.is_tex ? TEX_SCALE : POS_SCALE;
		prod   = req.operand * factor;
		if (req.is_tex) begin
			result = RES_W'(prod[OPND_W+7:16]);
		end else begin
			result = prod[8 +: RES_W];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/vertex_pack_dedup_indexer_unit.sv */
// Top level: corner packer with hashed vertex dedup table.
// Flow: an accepted corner passes through four scale steps, a probe read, a check and an
// output load before m_tvalid rises; each extra probe repeats the probe read and the check.
// One corner is in flight: the next is taken once the result is loaded, held by output stalls.
// Reset (arst_n low) clears control state, then a clearing pass over all TABLE_SLOTS (8192)
// slots runs with s_tready low; the same pass runs when the 4-bit mesh epoch wraps.
`default_nettype none
module vertex_pack_dedup_indexer_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// pos_x[15:0], pos_y[31:16], pos_z[47:32], norm_x[63:48], norm_y[79:64],
	// norm_z[95:80], tex_u[112:96], zero fill
	input  wire logic [119:0] s_tdata,
	// first_of_mesh[0]
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// vert_idx[11:0], packed_vertex[43:12], zero fill
	output logic [47:0]       m_tdata,
	// is_new[0], status[2:1]
	output logic [2:0]        m_tuser
);
	import vpdi_pkg::*;
	`include "vertex_pack_dedup_indexer_unit_assert.svh"

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CLEAR = 6'b000010,
		S_SCALE = 6'b000100,
		S_PROBE = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// held corner
	logic [15:0] pos_q [3];
	logic [15:0] nx_q, ny_q, nz_q;
	logic [16:0] tex_q;

	logic [1:0]         step_q;
	logic [KEY_W-1:0]   word_q;
	logic               over_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W:0]    probe_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [VCNT_W-1:0]  vcount_q;
	logic [SLOT_W-1:0]  clr_q;
	logic               pend_q;
	logic [IDX_W-1:0]   index_q;
	logic               new_q;
	logic               full_q;

	logic [47:0] m_tdata_q;
	logic [2:0]  m_tuser_q;
	logic        m_tvalid_q;

	// shared scale unit
	scale_req_t       sreq;
	logic [RES_W-1:0] sres;
	logic [15:0]      axis_raw;
	logic [16:0]      axis_abs;

	vpdi_scale u_scale (.req(sreq), .result(sres));

	always_comb begin
		case (step_q)
			2'd0:    axis_raw = pos_q[0];
			2'd1:    axis_raw = pos_q[1];
			default: axis_raw = pos_q[2];
		endcase
		axis_abs = axis_raw[15] ? (17'd0 - {1'b1, axis_raw}) : {1'b0, axis_raw};
		sreq.is_tex  = (step_q == 2'd3);
		sreq.operand = sreq.is_tex ? tex_q : axis_abs;
	end

	// normal code: first axis whose truncated value is nonzero
	function automatic logic [2:0] norm_code(input logic signed [15:0] x,
	                                         input logic signed [15:0] y,
	                                         input logic signed [15:0] z);
		logic [2:0] c;
		if (x <= -16'sd256)     c = 3'd0;
		else if (x >= 16'sd256) c = 3'd1;
		else if (y <= -16'sd256) c = 3'd2;
		else if (y >= 16'sd256) c = 3'd3;
		else if (z <= -16'sd256) c = 3'd4;
		else if (z >= 16'sd256) c = 3'd5;
		else                    c = NORMAL_NONE;
		return c;
	endfunction

	logic [2:0] ncode;
	assign ncode = norm_code(nx_q, ny_q, nz_q);

	// slot table: {epoch, key, index}; an entry counts only under the current epoch
	logic                ram_we;
	logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
	logic                hit_valid, hit_match, at_limit, table_done;

	vpdi_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_slots (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign ram_raddr  = (probe_q == '0) ? slot_hash(word_q) : slot_q;
	assign hit_valid  = (ram_rdata[ENTRY_W-1 -: EPOCH_W] == epoch_q);
	assign hit_match  = hit_valid && (ram_rdata[IDX_W +: KEY_W] == word_q);
	assign at_limit   = (vcount_q >= VCNT_W'(VLIMIT));
	assign table_done = (probe_q + 1'b1) == (SLOT_W+1)'(TABLE_SLOTS);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = {epoch_q, word_q, vcount_q[IDX_W-1:0]};
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_CHECK && !hit_valid && !at_limit) begin
			ram_we = 1'b1;
		end
	end

	logic [1:0] status_c;
	always_comb begin
		if (ncode == NORMAL_NONE) status_c = ST_NONORM;
		else if (over_q)          status_c = ST_OVER;
		else if (full_q)          status_c = ST_FULL;
		else                      status_c = ST_OK;
	end

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pos_q[0] <= s_tdata[15:0];
			pos_q[1] <= s_tdata[31:16];
			pos_q[2] <= s_tdata[47:32];
			nx_q     <= s_tdata[63:48];
			ny_q     <= s_tdata[79:64];
			nz_q     <= s_tdata[95:80];
			tex_q    <= s_tdata[112:96];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			step_q     <= '0;
			word_q     <= '0;
			over_q     <= 1'b0;
			slot_q     <= '0;
			probe_q    <= '0;
			epoch_q    <= '0;
			vcount_q   <= '0;
			clr_q      <= '0;
			pend_q     <= 1'b0;
			index_q    <= '0;
			new_q      <= 1'b0;
			full_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			// S_DONE owns the output valid while it loads a result
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						step_q <= '0;
						over_q <= 1'b0;
						word_q <= '0;
						if (s_tuser) begin
							vcount_q <= '0;
							if (epoch_q == '1) begin
								// epoch wrap: sweep stale entries first
								clr_q   <= '0;
								pend_q  <= 1'b1;
								state_q <= S_CLEAR;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= S_SCALE;
							end
						end else begin
							state_q <= S_SCALE;
						end
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
						epoch_q <= EPOCH_W'(1);
						pend_q  <= 1'b0;
						state_q <= pend_q ? S_SCALE : S_IDLE;
					end
				end
				S_SCALE: begin
					step_q <= step_q + 1'b1;
					case (step_q)
						2'd0: begin
							word_q[6:0] <= {axis_raw[15] && (sres != '0), sres[5:0]};
							over_q      <= over_q | (|sres[RES_W-1:6]);
						end
						2'd1: begin
							word_q[13:7] <= {axis_raw[15] && (sres != '0), sres[5:0]};
							over_q       <= over_q | (|sres[RES_W-1:6]);
						end
						2'd2: begin
							word_q[20:14] <= {axis_raw[15] && (sres != '0), sres[5:0]};
							over_q        <= over_q | (|sres[RES_W-1:6]);
						end
						default: begin
							word_q[23:21] <= ncode;
							word_q[31:24] <= (|sres[RES_W-1:8]) ? 8'hFF : sres[7:0];
							probe_q       <= '0;
							state_q       <= S_PROBE;
						end
					endcase
				end
				S_PROBE: begin
					slot_q  <= ram_raddr;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					new_q  <= 1'b0;
					full_q <= 1'b0;
					if (!hit_valid) begin
						if (at_limit) begin
							full_q  <= 1'b1;
							index_q <= '0;
						end else begin
							index_q  <= vcount_q[IDX_W-1:0];
							new_q    <= 1'b1;
							vcount_q <= vcount_q + 1'b1;
						end
						state_q <= S_DONE;
					end else if (hit_match) begin
						index_q <= ram_rdata[IDX_W-1:0];
						state_q <= S_DONE;
					end else if (table_done) begin
						full_q  <= 1'b1;
						index_q <= '0;
						state_q <= S_DONE;
					end else begin
						probe_q <= probe_q + 1'b1;
						slot_q  <= slot_q + 1'b1;
						state_q <= S_PROBE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'd0, word_q, index_q};
						m_tuser_q  <= {status_c, new_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// probe slot register follows the read address in the probe step
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`VPDI_ASSERT(a_insert_free, (state_q == S_CHECK && ram_we) |-> !hit_valid)
	`VPDI_ASSERT(a_vcount_limit, vcount_q <= VCNT_W'(VLIMIT))
	`VPDI_ASSERT(a_new_not_full, (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] != ST_FULL))
	`VPDI_ASSERT_NEXT(a_done_loads, (state_q == S_DONE && !m_tvalid_q), m_tvalid_q)
endmodule
`default_nettype wire
